### sv/sgd_momentum_update_macros.svh
// ----------------------------------------------------------------------------
// SGD momentum update - assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SGD_MOMENTUM_UPDATE_MACROS_SVH
`define SGD_MOMENTUM_UPDATE_MACROS_SVH

// same-cycle implication, off during reset
`define SGDM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SGDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle check that also runs during reset
`define SGDM_ASSERT_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

### sv/sgdm_pkg.sv
// ----------------------------------------------------------------------------
// sgdm_pkg
// Types, constants and binary32 pipeline step functions for the SGD engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sgdm_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned ELEM_W          = 10;
  localparam int unsigned CFG_IDX_W       = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOM  = 2'd2;

  // request kinds and modes
  localparam logic REQ_LOAD      = 1'b0;
  localparam logic REQ_UPDATE    = 1'b1;
  localparam logic MODE_SGD      = 1'b0;
  localparam logic MODE_MOMENTUM = 1'b1;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;

  // per-request context carried down the pipeline
  typedef struct packed {
    logic        req;
    logic        last;
    logic        err;
    logic        mode;
    logic [31:0] grad;
    logic [31:0] p;
    logic [31:0] v;
    logic [31:0] nv;
  } ctx_t;

  // exact unrounded value: sig * 2^x, or a special result
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sign;
    logic signed [10:0] x;
    logic [47:0]        sig;
  } raw_t;

  // after leading-one search
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sign;
    logic               zero;
    logic               ovf;
    logic [7:0]         eb;
    logic signed [11:0] rs;
    logic [47:0]        sig;
  } nrm_t;

  // aligned, ready to round
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_bits;
    logic        sign;
    logic        zero;
    logic        ovf;
    logic [7:0]  e;
    logic [23:0] mant;
    logic        g;
    logic        s;
  } rnd_t;

  // adder operands after alignment
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sa;
    logic               sb;
    logic signed [10:0] x;
    logic [26:0]        ma;
    logic [26:0]        mb;
  } aln_t;

  function automatic logic [23:0] f_sig(input logic [31:0] f);
    return {(f[30:23] != 8'd0), f[22:0]};
  endfunction

  function automatic logic [7:0] f_exp(input logic [31:0] f);
    return (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
  endfunction

  function automatic logic f_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic f_inf(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
  endfunction

  function automatic logic f_zero(input logic [31:0] f);
    return f[30:0] == 31'd0;
  endfunction

  // NaN, infinite, or negative other than -0
  function automatic logic bad_nonneg(input logic [31:0] f);
    return (f[30:23] == 8'hFF) || (f[31] && (f[30:0] != 31'd0));
  endfunction

  function automatic logic cfg_bad(input logic mode, input logic [31:0] lr,
                                   input logic [31:0] mom);
    logic mom_bad;
    mom_bad = bad_nonneg(mom) || (!mom[31] && (mom >= ONE_BITS));
    return bad_nonneg(lr) || ((mode == MODE_MOMENTUM) && mom_bad);
  endfunction

  // multiply: specials and mantissa product
  function automatic raw_t fp_mul_s1(input logic [31:0] a, input logic [31:0] b);
    raw_t r;
    logic [23:0] sa;
    logic [23:0] sb;
    r  = '0;
    sa = f_sig(a);
    sb = f_sig(b);
    r.sign = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b) || (f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b))) begin
      r.spec      = 1'b1;
      r.spec_bits = QNAN_BITS;
    end else if (f_inf(a) || f_inf(b)) begin
      r.spec      = 1'b1;
      r.spec_bits = {r.sign, 8'hFF, 23'd0};
    end else begin
      r.sig = sa * sb;
      r.x   = $signed({3'b000, f_exp(a)}) + $signed({3'b000, f_exp(b)}) - 11'sd300;
    end
    return r;
  endfunction

  // add: specials, order by magnitude, align smaller operand with sticky
  function automatic aln_t fp_add_s1(input logic [31:0] a, input logic [31:0] b);
    aln_t        r;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  d;
    logic [4:0]  sh;
    logic [26:0] mext;
    logic [26:0] sft;
    r = '0;
    if (f_nan(a) || f_nan(b) || (f_inf(a) && f_inf(b) && (a[31] != b[31]))) begin
      r.spec      = 1'b1;
      r.spec_bits = QNAN_BITS;
    end else if (f_inf(a)) begin
      r.spec      = 1'b1;
      r.spec_bits = a;
    end else if (f_inf(b)) begin
      r.spec      = 1'b1;
      r.spec_bits = b;
    end
    big  = (b[30:0] > a[30:0]) ? b : a;
    sml  = (b[30:0] > a[30:0]) ? a : b;
    d    = f_exp(big) - f_exp(sml);
    sh   = (d > 8'd31) ? 5'd31 : d[4:0];
    mext = {f_sig(sml), 3'b000};
    sft  = mext >> sh;
    r.sa = big[31];
    r.sb = sml[31];
    r.x  = $signed({3'b000, f_exp(big)}) - 11'sd153;
    r.ma = {f_sig(big), 3'b000};
    r.mb = sft | {26'd0, ((sft << sh) != mext)};
    return r;
  endfunction

  // add: magnitude add or subtract
  function automatic raw_t fp_add_s2(input aln_t a);
    raw_t        r;
    logic [27:0] sum;
    r = '0;
    if (a.sa == a.sb) sum = {1'b0, a.ma} + {1'b0, a.mb};
    else              sum = {1'b0, a.ma} - {1'b0, a.mb};
    r.spec      = a.spec;
    r.spec_bits = a.spec_bits;
    // exact cancellation gives +0 unless both inputs are negative
    r.sign = (sum == 28'd0) ? (a.sa & a.sb) : a.sa;
    r.x    = a.x;
    r.sig  = {20'd0, sum};
    return r;
  endfunction

  // normalize: leading one, shift distance and exponent field
  function automatic nrm_t fp_nrm_s1(input raw_t r);
    nrm_t               n;
    logic [5:0]         p;
    logic signed [11:0] xw;
    logic signed [11:0] rs1;
    logic signed [11:0] rs2;
    logic signed [11:0] eb;
    p = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (r.sig[i]) p = 6'(i);
    end
    xw  = {r.x[10], r.x};
    rs1 = $signed({6'd0, p}) - 12'sd23;
    rs2 = -12'sd149 - xw;
    n.rs        = (rs1 > rs2) ? rs1 : rs2;
    eb          = xw + n.rs + 12'sd150;
    n.eb        = eb[7:0];
    n.ovf       = eb > 12'sd254;
    n.zero      = r.sig == 48'd0;
    n.spec      = r.spec;
    n.spec_bits = r.spec_bits;
    n.sign      = r.sign;
    n.sig       = r.sig;
    return n;
  endfunction

  // normalize: shift to 24 bits, guard and sticky
  function automatic rnd_t fp_nrm_s2(input nrm_t n);
    rnd_t               r;
    logic signed [11:0] nrs;
    logic [6:0]         sh;
    logic [73:0]        ext;
    logic [73:0]        t;
    r.spec      = n.spec;
    r.spec_bits = n.spec_bits;
    r.sign      = n.sign;
    r.zero      = n.zero;
    r.ovf       = n.ovf;
    nrs         = -n.rs;
    ext         = {n.sig, 26'd0};
    sh          = (n.rs > 12'sd80) ? 7'd80 : n.rs[6:0];
    t           = ext >> sh;
    if (n.rs < 12'sd0) begin
      r.mant = n.sig[23:0] << nrs[4:0];
      r.g    = 1'b0;
      r.s    = 1'b0;
    end else begin
      r.mant = t[49:26];
      r.g    = t[25];
      r.s    = (t[24:0] != 25'd0) || ((t << sh) != ext);
    end
    r.e = r.mant[23] ? n.eb : 8'd0;
    return r;
  endfunction

  // round to nearest even and pack
  function automatic logic [31:0] fp_nrm_s3(input rnd_t r);
    logic [30:0] packed_v;
    logic        inc;
    logic [31:0] res;
    packed_v = {r.e, r.mant[22:0]};
    inc      = r.g & (r.s | r.mant[0]);
    if (r.spec)      res = r.spec_bits;
    else if (r.zero) res = {r.sign, 31'd0};
    else if (r.ovf)  res = {r.sign, 8'hFF, 23'd0};
    else             res = {r.sign, packed_v + {30'd0, inc}};
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/sgdm_ram.sv
// ----------------------------------------------------------------------------
// sgdm_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/sgd_momentum_update.sv
// ----------------------------------------------------------------------------
// sgd_momentum_update
// SGD / SGD-with-momentum engine over a binary32 parameter store.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall; a request is taken at a rising edge
//   with in_valid high and in_stall low. A load request writes a parameter
//   and clears its velocity; an update request applies one gradient element.
//   Each request gives one result on out_valid/out_stall.
//   Throughput: one request per cycle while no index hazard or output
//   stall holds the flow, set by the 19-stage pipeline of two multiplies
//   and two adds with one RAM port pair.
//   A request whose index matches one still in flight waits in the input
//   register until that one has written back; a stall on the output
//   lengthens the wait.
//   Configuration (mode, learning rate, momentum) is written through
//   cfg_write/cfg_index/cfg_data while no request is in flight.
//   A stall on the output holds the result; bubbles upstream still close
//   up and new requests are taken until the pipeline is full.
//   Reset clears the pipeline, the step count and the configuration. The
//   stores are not cleared: an entry must be loaded before it is updated.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_momentum_update #(
  parameter int unsigned STORE_DEPTH = sgdm_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             req_type,
  input  wire logic [sgdm_pkg::ELEM_W-1:0]      elem_index,
  input  wire logic [sgdm_pkg::WORD_W-1:0]      operand_bits,
  input  wire logic                             last_of_step,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [sgdm_pkg::WORD_W-1:0]      param_bits,
  output logic      [sgdm_pkg::WORD_W-1:0]      velocity_bits,
  output logic      [sgdm_pkg::WORD_W-1:0]      step_number,
  output logic                                  config_error,
  // configuration
  input  wire logic                             cfg_write,
  input  wire logic [sgdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sgdm_pkg::WORD_W-1:0]      cfg_data
);

  import sgdm_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned NS = 19;

  // configuration registers
  logic        mode;
  logic [31:0] lr;
  logic [31:0] mom;

  // input register
  logic        valid0;
  logic        in0_req;
  logic [9:0]  in0_elem;
  logic [31:0] in0_opnd;
  logic        in0_last;
  logic [9:0]  red;
  logic [31:0] red_w;
  logic [AW-1:0] idx0;
  ctx_t        ctx0;
  logic        hazard;
  logic        move0;

  // pipeline control and context
  logic          valid [1:NS];
  logic          en    [1:NS];
  ctx_t          ctx   [1:NS-1];
  logic [AW-1:0] idx   [1:NS-1];
  ctx_t          ctx2_in;
  ctx_t          ctx10_in;

  // arithmetic stage registers
  raw_t        pr2, pr7, pr11, pr16;
  nrm_t        n3, n8, n12, n17;
  rnd_t        r4, r9, r13, r18;
  logic [31:0] mv5;
  logic [31:0] sc14;
  aln_t        a6, a15;
  logic [31:0] dir10;

  // RAM ports
  logic [31:0] ram_p;
  logic [31:0] ram_v;
  logic        wr;
  logic        wr_v;

  // write-back
  logic        upd18;
  logic [31:0] np18;
  logic [31:0] p_res;
  logic [31:0] v_res;
  logic [31:0] step_cnt;
  logic [31:0] step_cnt_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SGD;
      lr   <= '0;
      mom  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODE: mode <= cfg_data[0];
        CFG_LR:   lr   <= cfg_data;
        CFG_MOM:  mom  <= cfg_data;
        default: ;
      endcase
    end
  end

  // index reduced modulo the store depth
  always_comb begin
    red = in0_elem;
    for (int k = ELEM_W - 1; k >= 0; k--) begin
      if ((64'(STORE_DEPTH) << k) < (64'd1 << ELEM_W)) begin
        if (red >= ELEM_W'(STORE_DEPTH << k)) red = red - ELEM_W'(STORE_DEPTH << k);
      end
    end
    red_w = 32'(red);
    idx0  = red_w[AW-1:0];
  end

  // hold a request while an earlier one to the same entry is in flight
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k < NS; k++) begin
      if (valid[k] && (idx[k] == idx0)) hazard = 1'b1;
    end
  end

  // stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS] = !valid[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign move0    = valid0 && !hazard && en[1];
  assign in_stall = valid0 && !move0;
  assign out_valid = valid[NS];

  always_comb begin
    ctx0      = '0;
    ctx0.req  = in0_req;
    ctx0.last = in0_last;
    ctx0.err  = cfg_bad(mode, lr, mom);
    ctx0.mode = mode;
    ctx0.grad = in0_opnd;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      for (int k = 1; k <= NS; k++) valid[k] <= 1'b0;
    end else begin
      if (in_valid && !in_stall) valid0 <= 1'b1;
      else if (move0)            valid0 <= 1'b0;
      if (en[1]) valid[1] <= move0;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) valid[k] <= valid[k-1];
      end
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in0_req  <= req_type;
      in0_elem <= elem_index;
      in0_opnd <= operand_bits;
      in0_last <= last_of_step;
    end
  end

  // store words join the context at stage 2, new velocity at stage 10
  always_comb begin
    ctx2_in     = ctx[1];
    ctx2_in.p   = ram_p;
    ctx2_in.v   = ram_v;
    ctx10_in    = ctx[9];
    ctx10_in.nv = fp_nrm_s3(r9);
  end

  // context travels with each request
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ctx[1] <= ctx0;
      idx[1] <= idx0;
    end
    for (int k = 2; k < NS; k++) begin
      if (en[k]) begin
        if (k == 2)       ctx[k] <= ctx2_in;
        else if (k == 10) ctx[k] <= ctx10_in;
        else              ctx[k] <= ctx[k-1];
        idx[k] <= idx[k-1];
      end
    end
  end

  assign dir10 = (ctx[10].mode == MODE_MOMENTUM) ? ctx[10].nv : ctx[10].grad;

  // arithmetic: m*v, +g, lr*dir, p-
  always_ff @(posedge clk) begin
    if (en[2])  pr2  <= fp_mul_s1(mom, ram_v);
    if (en[3])  n3   <= fp_nrm_s1(pr2);
    if (en[4])  r4   <= fp_nrm_s2(n3);
    if (en[5])  mv5  <= fp_nrm_s3(r4);
    if (en[6])  a6   <= fp_add_s1(mv5, ctx[5].grad);
    if (en[7])  pr7  <= fp_add_s2(a6);
    if (en[8])  n8   <= fp_nrm_s1(pr7);
    if (en[9])  r9   <= fp_nrm_s2(n8);
    if (en[11]) pr11 <= fp_mul_s1(lr, dir10);
    if (en[12]) n12  <= fp_nrm_s1(pr11);
    if (en[13]) r13  <= fp_nrm_s2(n12);
    if (en[14]) sc14 <= fp_nrm_s3(r13);
    if (en[15]) a15  <= fp_add_s1(ctx[14].p, {~sc14[31], sc14[30:0]});
    if (en[16]) pr16 <= fp_add_s2(a15);
    if (en[17]) n17  <= fp_nrm_s1(pr16);
    if (en[18]) r18  <= fp_nrm_s2(n17);
  end

  // result selection and write-back
  always_comb begin
    upd18 = ctx[NS-1].req == REQ_UPDATE;
    np18  = fp_nrm_s3(r18);
    if (ctx[NS-1].err) begin
      p_res = ctx[NS-1].p;
      v_res = (ctx[NS-1].mode == MODE_MOMENTUM) ? ctx[NS-1].v : 32'd0;
    end else if (!upd18) begin
      p_res = ctx[NS-1].grad;
      v_res = 32'd0;
    end else begin
      p_res = np18;
      v_res = (ctx[NS-1].mode == MODE_MOMENTUM) ? ctx[NS-1].nv : 32'd0;
    end
    wr   = valid[NS-1] && en[NS] && !ctx[NS-1].err;
    wr_v = wr && (!upd18 || (ctx[NS-1].mode == MODE_MOMENTUM));
    step_cnt_next = step_cnt + {31'd0, (wr && upd18 && ctx[NS-1].last)};
  end

  always_ff @(posedge clk) begin
    if (rst) step_cnt <= '0;
    else     step_cnt <= step_cnt_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[NS]) begin
      param_bits    <= p_res;
      velocity_bits <= v_res;
      step_number   <= step_cnt_next;
      config_error  <= ctx[NS-1].err;
    end
  end

  // parameter and velocity stores
  sgdm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_param_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (idx[NS-1]),
    .wdata (p_res),
    .re    (en[1]),
    .raddr (idx0),
    .rdata (ram_p)
  );

  sgdm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_velocity_ram (
    .clk   (clk),
    .we    (wr_v),
    .waddr (idx[NS-1]),
    .wdata (v_res),
    .re    (en[1]),
    .raddr (idx0),
    .rdata (ram_v)
  );

endmodule

`default_nettype wire

### sv/sgdm_checker.sv
// ----------------------------------------------------------------------------
// sgdm_port_checks
// Port-level checks for the SGD engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sgd_momentum_update_macros.svh"

module sgdm_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] param_bits,
  input wire logic [31:0] velocity_bits,
  input wire logic [31:0] step_number,
  input wire logic        config_error
);

  logic       in_take;
  logic       out_take;
  logic [7:0] pending;
  logic [31:0] last_step;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else     pending <= pending + {7'd0, in_take} - {7'd0, out_take};
  end

  // step count of the last delivered result
  always_ff @(posedge clk) begin
    if (rst)           last_step <= '0;
    else if (out_take) last_step <= step_number;
  end

  `SGDM_ASSERT_RST(a_reset_idle, clk, rst, !out_valid, "result valid right after reset")

  `SGDM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(param_bits) && $stable(velocity_bits) && $stable(step_number) && $stable(config_error), "stalled result changed")

  `SGDM_ASSERT_IMPL(a_no_orphan, clk, rst, out_valid, pending != 8'd0, "result without a pending request")

  `SGDM_ASSERT_IMPL(a_step_rate, clk, rst, out_take, (step_number == last_step) || (step_number == last_step + 32'd1), "step count jumped")

  `SGDM_ASSERT_IMPL(a_err_no_step, clk, rst, out_take && config_error, step_number == last_step, "rejected request moved the step count")

endmodule

bind sgd_momentum_update sgdm_port_checks u_checker (.*);

`default_nettype wire
